// File: design/positional_dither_offset_assert.svh
// Assertion macros shared by the dither offset block.
`ifndef POSITIONAL_DITHER_OFFSET_ASSERT_SVH
`define POSITIONAL_DITHER_OFFSET_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PDO_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dither offset check failed");

// Next-cycle implication, ignored while reset is asserted.
`define PDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dither offset check failed");

// Next-cycle implication that also covers the reset itself.
`define PDO_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dither offset reset check failed");

`endif

// File: design/pdo_pkg.sv
// Package with types and constants of the positional dither offset block.
package pdo_pkg;

    localparam int unsigned DEF_MAX_CHANNELS = 4;
    localparam int unsigned NUM_OUT          = 4;
    localparam int unsigned CHAN_W           = 8;
    localparam int unsigned COORD_W          = 16;
    localparam int unsigned IN_DATA_W        = 2 * COORD_W + NUM_OUT * CHAN_W;
    localparam int unsigned OUT_DATA_W       = NUM_OUT * CHAN_W;
    localparam int unsigned CFG_DATA_W       = 3;
    localparam int unsigned CFG_IDX_W        = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_MODE       = 1'b1;

    // Mask A constants.
    localparam int unsigned A_CHAN_MUL = 67;
    localparam logic [15:0] A_ROW_MUL  = 16'd236;
    localparam logic [15:0] A_MUL      = 16'd119;

    // Mask X constants.
    localparam int unsigned X_CHAN_MUL = 29;
    localparam logic [17:0] X_ROW_MUL  = 18'd149;
    localparam logic [19:0] X_MUL      = 20'd1234;

    typedef enum logic {
        MASK_ADD = 1'b0,
        MASK_XOR = 1'b1
    } t_mask_mode;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] channels_in_use;
        t_mask_mode            mask_mode;
    } t_cfg;

    localparam logic [CFG_DATA_W-1:0] RST_CHANNELS_IN_USE = 3'd3;
    localparam t_mask_mode            RST_MASK_MODE       = MASK_XOR;

endpackage

// File: design/pdo_lane.sv
// One channel lane: position-based dither offset, add and saturate.
module pdo_lane #(
    parameter int unsigned LANE = 0
) (
    input  logic [pdo_pkg::COORD_W-1:0] i_column,
    input  logic [pdo_pkg::COORD_W-1:0] i_row,
    input  logic [pdo_pkg::CHAN_W-1:0]  i_sample,
    input  pdo_pkg::t_mask_mode         i_mode,
    output logic [pdo_pkg::CHAN_W-1:0]  o_chan
);

    localparam logic [7:0] LANE_A = 8'((pdo_pkg::A_CHAN_MUL * LANE) % 256);
    localparam logic [8:0] LANE_X = 9'((pdo_pkg::X_CHAN_MUL * LANE) % 512);

    logic [15:0]       row_a_prod;
    logic [7:0]        sum_a;
    logic [15:0]       m_a_prod;
    logic signed [8:0] d_a;
    logic signed [8:0] adj_a;
    logic [17:0]       row_x_prod;
    logic [8:0]        col_x;
    logic [8:0]        mix_x;
    logic [19:0]       m_x_prod;
    logic signed [9:0] d_x;
    logic signed [9:0] adj_x;
    logic signed [5:0] off;
    logic signed [9:0] sum_v;

    always_comb begin
        // Mask A only needs the low byte of every term.
        row_a_prod = {8'd0, i_row[7:0]} * pdo_pkg::A_ROW_MUL;
        sum_a      = i_column[7:0] + LANE_A + row_a_prod[7:0];
        m_a_prod   = {8'd0, sum_a} * pdo_pkg::A_MUL;
        d_a        = $signed({1'b0, m_a_prod[7:0]}) - 9'sd128;
        adj_a      = d_a + (d_a[8] ? 9'sd3 : 9'sd0);

        // Mask X only needs the low nine bits of every term.
        row_x_prod = {9'd0, i_row[8:0]} * pdo_pkg::X_ROW_MUL;
        col_x      = i_column[8:0] + LANE_X;
        mix_x      = col_x ^ row_x_prod[8:0];
        m_x_prod   = {11'd0, mix_x} * pdo_pkg::X_MUL;
        d_x        = $signed({1'b0, m_x_prod[8:0]}) - 10'sd256;
        adj_x      = d_x + (d_x[9] ? 10'sd7 : 10'sd0);

        // The bias before the shift makes the division truncate toward zero.
        off = (i_mode == pdo_pkg::MASK_XOR) ? $signed(adj_x[8:3]) : $signed(adj_a[7:2]);

        sum_v = $signed({2'b00, i_sample}) + $signed({{4{off[5]}}, off});
        if (sum_v[9]) begin
            o_chan = '0;
        end else if (sum_v[8]) begin
            o_chan = '1;
        end else begin
            o_chan = sum_v[7:0];
        end
    end

endmodule

// File: design/pdo_merge.sv
// Merge stage: masks unused lanes and holds the result item in the output register.
module pdo_merge #(
    parameter int unsigned MAX_CHANNELS = pdo_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [pdo_pkg::NUM_OUT-1:0][pdo_pkg::CHAN_W-1:0] i_lane,
    input  pdo_pkg::t_cfg                                 i_cfg,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [pdo_pkg::OUT_DATA_W-1:0]                o_data
);

    logic                                            r_valid;
    logic [pdo_pkg::NUM_OUT-1:0][pdo_pkg::CHAN_W-1:0] r_data;
    logic [pdo_pkg::NUM_OUT-1:0][pdo_pkg::CHAN_W-1:0] n_data;

    // A new item may enter when the output register is empty or when the held result leaves in the same cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        for (int c = 0; c < pdo_pkg::NUM_OUT; c++) begin
            if ((c < int'(i_cfg.channels_in_use)) && (c < int'(MAX_CHANNELS))) begin
                n_data[c] = i_lane[c];
            end else begin
                n_data[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// File: design/positional_dither_offset.sv
// Top level of the positional dither offset block.
//
// Input channel s_axis: one item per pixel with its column, row and four
// 8-bit channel samples. Output channel m_axis: one item per input item
// with the four dithered and saturated channels; channels at or beyond
// channels_in_use read as zero.
// Every channel runs in its own lane of constant multipliers, so a pixel is
// accepted every cycle while the receiver does not stall. The result is held
// in the output register from the cycle after the input item is accepted.
// When the receiver stalls, the output register holds its item and
// s_axis_tready drops until that item is taken; the result moves out and a
// new item moves in at the same edge when both sides are ready.
// Reset empties the output register and sets channels_in_use to 3 and
// mask_mode to the xor mask. Configuration writes through i_cfg_we,
// i_cfg_index and i_cfg_data take effect at the next edge; the user must
// make them while no item is in flight, and the block does not enforce this.
module positional_dither_offset #(
    parameter int unsigned MAX_CHANNELS = pdo_pkg::DEF_MAX_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // column, row, chan_in_0, chan_in_1, chan_in_2, chan_in_3 (lowest bit up)
    input  logic [pdo_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chan_out_0, chan_out_1, chan_out_2, chan_out_3 (lowest bit up)
    output logic [pdo_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [pdo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pdo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pdo_pkg::t_cfg                                    r_cfg;
    logic [pdo_pkg::COORD_W-1:0]                      column;
    logic [pdo_pkg::COORD_W-1:0]                      row;
    logic [pdo_pkg::NUM_OUT-1:0][pdo_pkg::CHAN_W-1:0] samples;
    logic [pdo_pkg::NUM_OUT-1:0][pdo_pkg::CHAN_W-1:0] lane_res;

    assign column  = s_axis_tdata[pdo_pkg::COORD_W-1:0];
    assign row     = s_axis_tdata[2*pdo_pkg::COORD_W-1:pdo_pkg::COORD_W];
    assign samples = s_axis_tdata[pdo_pkg::IN_DATA_W-1:2*pdo_pkg::COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channels_in_use <= pdo_pkg::RST_CHANNELS_IN_USE;
            r_cfg.mask_mode       <= pdo_pkg::RST_MASK_MODE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pdo_pkg::REG_CHANNELS_IN_USE) begin
                r_cfg.channels_in_use <= i_cfg_data;
            end else if (i_cfg_index == pdo_pkg::REG_MASK_MODE) begin
                r_cfg.mask_mode <= pdo_pkg::t_mask_mode'(i_cfg_data[0]);
            end
        end
    end

    for (genvar g = 0; g < pdo_pkg::NUM_OUT; g++) begin : g_lane
        if (g < MAX_CHANNELS) begin : g_used
            pdo_lane #(
                .LANE(g)
            ) u_lane (
                .i_column(column),
                .i_row   (row),
                .i_sample(samples[g]),
                .i_mode  (r_cfg.mask_mode),
                .o_chan  (lane_res[g])
            );
        end else begin : g_absent
            assign lane_res[g] = '0;
        end
    end

    pdo_merge #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_lane (lane_res),
        .i_cfg  (r_cfg),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (m_axis_tdata)
    );

`include "positional_dither_offset_assert.svh"

    // An accepted item always shows up in the output register.
    `PDO_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    // A held result that is not taken blocks the input side.
    `PDO_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // Reset leaves the output channel empty.
    `PDO_ASSERT_NEXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule
